// ===== sv/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptl_pkg: shared constants for the point-to-line distance core
// Distance field width and the comparison margin used by the root cells.
// ----------------------------------------------------------------------------
package ptl_pkg;

	// Width of the distance result; one root cell per bit
	localparam int DIST_BITS = 17;

	// Extra headroom bits on the trial-product compare
	localparam int CMP_MARGIN = 2;

endpackage

// ===== sv/ptl_front.sv =====
// ----------------------------------------------------------------------------
// ptl_front: cross product and squared norms
// Five stages: difference, products, cross and magnitude, squares, sums.
// Produces |c|^2, |d|^2 and the zero direction flag for each request.
// ----------------------------------------------------------------------------
module ptl_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_i,
	output logic                          ready_o,
	input  logic [COORD_WIDTH-1:0]        line_x,
	input  logic [COORD_WIDTH-1:0]        line_y,
	input  logic [COORD_WIDTH-1:0]        line_z,
	input  logic [COORD_WIDTH-1:0]        dir_x,
	input  logic [COORD_WIDTH-1:0]        dir_y,
	input  logic [COORD_WIDTH-1:0]        dir_z,
	input  logic [COORD_WIDTH-1:0]        query_x,
	input  logic [COORD_WIDTH-1:0]        query_y,
	input  logic [COORD_WIDTH-1:0]        query_z,
	output logic                          valid_o,
	input  logic                          ready_i,
	output logic [4*COORD_WIDTH+3:0]      csq,
	output logic [2*COORD_WIDTH+1:0]      dsq,
	output logic                          zero_dir
);

	localparam int CW  = COORD_WIDTH;
	localparam int VW  = CW + 1;        // difference width
	localparam int PW  = CW + VW;       // product width
	localparam int CXW = PW + 1;        // cross component width, signed
	localparam int CM  = CXW - 1;       // cross magnitude width
	localparam int SW  = 2 * CM + 2;    // |c|^2 width
	localparam int DW  = 2 * CW + 2;    // |d|^2 width

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [VW-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [CW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [CW-1:0] dx_s2, dy_s2, dz_s2;
	logic [CM-1:0] cx_s3, cy_s3, cz_s3;
	logic [CW-1:0] ax_s3, ay_s3, az_s3;
	logic [2*CM-1:0] cx2_s4, cy2_s4, cz2_s4;
	logic [2*CW-1:0] dx2_s4, dy2_s4, dz2_s4;
	logic [SW-1:0] csq_s5;
	logic [DW-1:0] dsq_s5;

	logic signed [CXW-1:0] cx_w, cy_w, cz_w;
	logic signed [CXW-1:0] cxn_w, cyn_w, czn_w;
	logic signed [CW:0]    dxe_w, dye_w, dze_w;
	logic signed [CW:0]    dxn_w, dyn_w, dzn_w;

	// stage enables ripple back from the consumer
	assign en5 = !valid_s5 || ready_i;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign ready_o = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= valid_i;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: v = query - line
	always_ff @(posedge clk) begin
		if (en1 && valid_i) begin
			vx_s1 <= $signed({query_x[CW-1], query_x}) - $signed({line_x[CW-1], line_x});
			vy_s1 <= $signed({query_y[CW-1], query_y}) - $signed({line_y[CW-1], line_y});
			vz_s1 <= $signed({query_z[CW-1], query_z}) - $signed({line_z[CW-1], line_z});
			dx_s1 <= $signed(dir_x);
			dy_s1 <= $signed(dir_y);
			dz_s1 <= $signed(dir_z);
		end
	end

	// stage 2: the six cross-product terms
	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			p0_s2 <= PW'(dy_s1 * vz_s1);
			p1_s2 <= PW'(dz_s1 * vy_s1);
			p2_s2 <= PW'(dz_s1 * vx_s1);
			p3_s2 <= PW'(dx_s1 * vz_s1);
			p4_s2 <= PW'(dx_s1 * vy_s1);
			p5_s2 <= PW'(dy_s1 * vx_s1);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dz_s2 <= dz_s1;
		end
	end

	// stage 3: cross components and magnitudes
	always_comb begin
		cx_w  = CXW'(p0_s2) - CXW'(p1_s2);
		cy_w  = CXW'(p2_s2) - CXW'(p3_s2);
		cz_w  = CXW'(p4_s2) - CXW'(p5_s2);
		cxn_w = -cx_w;
		cyn_w = -cy_w;
		czn_w = -cz_w;
		dxe_w = (CW+1)'(dx_s2);
		dye_w = (CW+1)'(dy_s2);
		dze_w = (CW+1)'(dz_s2);
		dxn_w = -dxe_w;
		dyn_w = -dye_w;
		dzn_w = -dze_w;
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			cx_s3 <= cx_w[CXW-1] ? cxn_w[CM-1:0] : cx_w[CM-1:0];
			cy_s3 <= cy_w[CXW-1] ? cyn_w[CM-1:0] : cy_w[CM-1:0];
			cz_s3 <= cz_w[CXW-1] ? czn_w[CM-1:0] : cz_w[CM-1:0];
			ax_s3 <= dxe_w[CW] ? dxn_w[CW-1:0] : dxe_w[CW-1:0];
			ay_s3 <= dye_w[CW] ? dyn_w[CW-1:0] : dye_w[CW-1:0];
			az_s3 <= dze_w[CW] ? dzn_w[CW-1:0] : dze_w[CW-1:0];
		end
	end

	// stage 4: squares
	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			cx2_s4 <= cx_s3 * cx_s3;
			cy2_s4 <= cy_s3 * cy_s3;
			cz2_s4 <= cz_s3 * cz_s3;
			dx2_s4 <= ax_s3 * ax_s3;
			dy2_s4 <= ay_s3 * ay_s3;
			dz2_s4 <= az_s3 * az_s3;
		end
	end

	// stage 5: sums of squares
	always_ff @(posedge clk) begin
		if (en5 && valid_s4) begin
			csq_s5 <= SW'(cx2_s4) + SW'(cy2_s4) + SW'(cz2_s4);
			dsq_s5 <= DW'(dx2_s4) + DW'(dy2_s4) + DW'(dz2_s4);
		end
	end

	assign valid_o  = valid_s5;
	assign csq      = csq_s5;
	assign dsq      = dsq_s5;
	assign zero_dir = (dsq_s5 == '0);

endmodule

// ===== sv/ptl_cell.sv =====
// ----------------------------------------------------------------------------
// ptl_cell: one bit of the distance root search
// Tries setting bit BIT of r; keeps it when (r+2^b)^2*|d|^2 <= |c|^2.
// Tracks r*|d|^2 and r^2*|d|^2 so the trial needs only shifts and adds.
// ----------------------------------------------------------------------------
module ptl_cell #(
	parameter int BIT = 0,
	parameter int SW  = 68,
	parameter int DW  = 34
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_i,
	output logic                                ready_o,
	input  logic [SW-1:0]                       csq_i,
	input  logic [DW-1:0]                       dsq_i,
	input  logic                                zero_i,
	input  logic [ptl_pkg::DIST_BITS-1:0]       r_i,
	input  logic [ptl_pkg::DIST_BITS+DW-1:0]    rd_i,
	input  logic [SW-1:0]                       r2d_i,
	output logic                                valid_o,
	input  logic                                ready_i,
	output logic [SW-1:0]                       csq_o,
	output logic [DW-1:0]                       dsq_o,
	output logic                                zero_o,
	output logic [ptl_pkg::DIST_BITS-1:0]       r_o,
	output logic [ptl_pkg::DIST_BITS+DW-1:0]    rd_o,
	output logic [SW-1:0]                       r2d_o
);

	localparam int RW  = ptl_pkg::DIST_BITS;
	localparam int RDW = RW + DW;
	localparam int PA  = (SW > 2 * RW + DW) ? SW : 2 * RW + DW;
	localparam int PW  = PA + ptl_pkg::CMP_MARGIN;

	logic          valid_q;
	logic [SW-1:0] csq_q, r2d_q;
	logic [DW-1:0] dsq_q;
	logic          zero_q;
	logic [RW-1:0] r_q;
	logic [RDW-1:0] rd_q;

	logic [PW-1:0] cand_w;
	logic          take_w;

	assign ready_o = !valid_q || ready_i;

	// trial: r2d + r*d*2^(b+1) + d*2^(2b)
	always_comb begin
		cand_w = PW'(r2d_i) + (PW'(rd_i) << (BIT + 1)) + (PW'(dsq_i) << (2 * BIT));
		take_w = (cand_w <= PW'(csq_i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	// hand the partial root on to the next cell
	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			csq_q  <= csq_i;
			dsq_q  <= dsq_i;
			zero_q <= zero_i;
			if (take_w) begin
				r_q   <= r_i | (RW'(1) << BIT);
				rd_q  <= rd_i + (RDW'(dsq_i) << BIT);
				r2d_q <= cand_w[SW-1:0];
			end else begin
				r_q   <= r_i;
				rd_q  <= rd_i;
				r2d_q <= r2d_i;
			end
		end
	end

	assign valid_o = valid_q;
	assign csq_o   = csq_q;
	assign dsq_o   = dsq_q;
	assign zero_o  = zero_q;
	assign r_o     = r_q;
	assign rd_o    = rd_q;
	assign r2d_o   = r2d_q;

endmodule

// ===== sv/point_to_line_distance_3d_core.sv =====
// ----------------------------------------------------------------------------
// point_to_line_distance_3d_core: distance from a point to a 3D line
// Floor of |d x (q - p)| / |d| in fixed point, zero direction flagged.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  request   | req_valid / req_stall | line_*, dir_*, query_* (signed)
//  response  | rsp_valid / rsp_stall | line_distance, zero_direction
//
//  One request per cycle sustained while the response is not stalled.
//  Five front stages form the cross product and squared norms; a row of
//  17 root cells then settles one distance bit each.
//  Every stage has its own valid bit, so a stalled response only holds
//  up requests once the whole row has filled.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d_core #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [COORD_WIDTH-1:0]             line_x,
	input  logic [COORD_WIDTH-1:0]             line_y,
	input  logic [COORD_WIDTH-1:0]             line_z,
	input  logic [COORD_WIDTH-1:0]             dir_x,
	input  logic [COORD_WIDTH-1:0]             dir_y,
	input  logic [COORD_WIDTH-1:0]             dir_z,
	input  logic [COORD_WIDTH-1:0]             query_x,
	input  logic [COORD_WIDTH-1:0]             query_y,
	input  logic [COORD_WIDTH-1:0]             query_z,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ptl_pkg::DIST_BITS-1:0]      line_distance,
	output logic                               zero_direction
);

	localparam int RW  = ptl_pkg::DIST_BITS;
	localparam int SW  = 4 * COORD_WIDTH + 4;
	localparam int DW  = 2 * COORD_WIDTH + 2;
	localparam int RDW = RW + DW;

	logic front_ready;

	// chain links: index 0 is the row input, index RW the row output
	logic           vld  [RW+1];
	logic           rdy  [RW+1];
	logic [SW-1:0]  csq  [RW+1];
	logic [DW-1:0]  dsq  [RW+1];
	logic           zro  [RW+1];
	logic [RW-1:0]  rr   [RW+1];
	logic [RDW-1:0] rd   [RW+1];
	logic [SW-1:0]  r2d  [RW+1];

	assign req_stall = !front_ready;

	// cross product and norms
	ptl_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_i  (req_valid),
		.ready_o  (front_ready),
		.line_x   (line_x),
		.line_y   (line_y),
		.line_z   (line_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.query_x  (query_x),
		.query_y  (query_y),
		.query_z  (query_z),
		.valid_o  (vld[0]),
		.ready_i  (rdy[0]),
		.csq      (csq[0]),
		.dsq      (dsq[0]),
		.zero_dir (zro[0])
	);

	assign rr[0]  = '0;
	assign rd[0]  = '0;
	assign r2d[0] = '0;

	// root search, most significant bit first
	for (genvar i = 0; i < RW; i++) begin : g_cell
		ptl_cell #(
			.BIT(RW - 1 - i),
			.SW (SW),
			.DW (DW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (vld[i]),
			.ready_o (rdy[i]),
			.csq_i   (csq[i]),
			.dsq_i   (dsq[i]),
			.zero_i  (zro[i]),
			.r_i     (rr[i]),
			.rd_i    (rd[i]),
			.r2d_i   (r2d[i]),
			.valid_o (vld[i+1]),
			.ready_i (rdy[i+1]),
			.csq_o   (csq[i+1]),
			.dsq_o   (dsq[i+1]),
			.zero_o  (zro[i+1]),
			.r_o     (rr[i+1]),
			.rd_o    (rd[i+1]),
			.r2d_o   (r2d[i+1])
		);
	end

	// last cell register is the response register
	assign rdy[RW]        = !rsp_stall;
	assign rsp_valid      = vld[RW];
	assign zero_direction = zro[RW];
	assign line_distance  = zro[RW] ? '0 : rr[RW];

endmodule

// ===== sv/ptl_checker.sv =====
// ----------------------------------------------------------------------------
// ptl_checker: port-level checks for the distance core
// Watches the request and response ports; bound to the top level.
// ----------------------------------------------------------------------------
module ptl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [ptl_pkg::DIST_BITS-1:0] line_distance,
	input logic                          zero_direction
);

	// with nothing waiting at the output, a request is never held off
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty response register");

	// a zero direction reports zero distance
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && zero_direction |-> line_distance == '0)
		else $error("zero direction with nonzero distance");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(line_distance)
			&& $stable(zero_direction))
		else $error("stalled response changed");

endmodule

bind point_to_line_distance_3d_core ptl_checker u_ptl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_stall      (req_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.line_distance  (line_distance),
	.zero_direction (zero_direction)
);
